[src/tcp_pkg.sv]
// Shared types and constants for the timer/counter with prescaler.
// No dependencies.
package tcp_pkg;

    localparam int COUNT_W  = 8;
    localparam int PHASE_W  = 10;
    localparam int LEFT_W   = 9;
    localparam int LIMIT_W  = 11;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEFT_W-1:0]  left_t;

    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_EDGE  = 2'd1;
    localparam op_t OP_READ  = 2'd2;
    localparam op_t OP_WRITE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EXT_CLOCK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE   = 2'd3;

    localparam count_t WRITE_OFFSET = 8'd2;

    // prescale divisor: 1 when bypassed, else 2 << sel
    function automatic left_t divisor(input logic bypass, input logic [2:0] sel);
        left_t d;
        if (bypass)
            d = left_t'(1);
        else
            d = left_t'(2) << sel;
        return d;
    endfunction

endpackage

[src/timer_counter_with_prescaler_unit.sv]
// Timer/counter with programmable prescaler, single registered pass per event.
// Depends on tcp_pkg.
//
//  channel | direction | payload                                  | handshake
//  s_*     | in        | tuser: operation; tdata: pin_rising,     | tvalid/tready
//          |           |        write_value                       |
//  m_*     | out       | tdata: read_data, overflow               | tvalid/tready
//  cfg_*   | in        | cfg_index, cfg_data                      | cfg_valid/cfg_ready
//
// One event per cycle unless stalled; each result appears the cycle after its event.
// The state update and the result register are loaded in the same edge.
// s_tready drops only while a result waits with m_tready low.
// rst_n clears the count, tick phase and sets the configuration to reset values.
// cfg_ready is always high.
module timer_counter_with_prescaler_unit
    import tcp_pkg::*;
#(
    parameter int TICKS_PER_INCREMENT = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] pin_rising, [8:1] write_value, rest zero
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] read_data, [8] overflow, rest zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               ext_reg;
    logic               falling_reg;
    logic               bypass_reg;
    logic [2:0]         sel_reg;

    count_t             count_reg, count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    left_t              left_reg, left_next;

    logic               out_valid_reg;
    count_t             rd_reg, rd_next;
    logic               ovf_reg, ovf_next;

    logic               accept;
    op_t                op;
    logic               pin_rising;
    count_t             wval;
    left_t              div;
    logic [LIMIT_W-1:0] limit;
    logic [PHASE_W-1:0] phase_inc;
    count_t             count_inc;
    logic               wrap;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign op         = s_tuser;
    assign pin_rising = s_tdata[0];
    assign wval       = s_tdata[8:1];

    assign div       = divisor(bypass_reg, sel_reg);
    assign limit     = LIMIT_W'(div) * LIMIT_W'(TICKS_PER_INCREMENT);
    assign phase_inc = phase_reg + PHASE_W'(1);
    assign count_inc = count_reg + count_t'(1);
    assign wrap      = (count_reg == '1);

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        left_next  = left_reg;
        rd_next    = '0;
        ovf_next   = 1'b0;
        unique case (op)
            OP_TICK:
            begin
                if (!ext_reg)
                begin
                    if (phase_inc == '0 || LIMIT_W'(phase_inc) >= limit)
                    begin
                        phase_next = '0;
                        count_next = count_inc;
                        ovf_next   = wrap;
                    end
                    else
                    begin
                        phase_next = phase_inc;
                    end
                end
            end
            OP_EDGE:
            begin
                if (ext_reg && (pin_rising == !falling_reg))
                begin
                    if (left_reg <= left_t'(1))
                    begin
                        left_next  = div;
                        count_next = count_inc;
                        ovf_next   = wrap;
                    end
                    else
                    begin
                        left_next = left_reg - left_t'(1);
                    end
                end
            end
            OP_READ:
            begin
                rd_next = count_reg;
            end
            OP_WRITE:
            begin
                count_next = wval + WRITE_OFFSET;
                if (ext_reg)
                    left_next = div;
                else
                    phase_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg     <= 1'b1;
            falling_reg <= 1'b1;
            bypass_reg  <= 1'b1;
            sel_reg     <= 3'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXT_CLOCK: ext_reg     <= cfg_data[0];
                REG_FALLING:   falling_reg <= cfg_data[0];
                REG_BYPASS:    bypass_reg  <= cfg_data[0];
                REG_PRESCALE:  sel_reg     <= cfg_data;
                default:       sel_reg     <= sel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            phase_reg     <= '0;
            left_reg      <= left_t'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                phase_reg <= phase_next;
                left_reg  <= left_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= rd_next;
            ovf_reg <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - COUNT_W - 1){1'b0}}, ovf_reg, rd_reg};

endmodule

[src/tcp_checker.sv]
// Port-level checks for the timer/counter with prescaler, bound to the top level.
// Depends on tcp_pkg and timer_counter_with_prescaler_unit.
module tcp_checker
    import tcp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [OP_W-1:0]       s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every accepted transaction yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> m_tvalid)
        else $error("accepted transaction gave no result");

    // input stalls only behind a waiting result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without cause");

    // overflow never comes with read data
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[COUNT_W] |-> m_tdata[COUNT_W-1:0] == '0)
        else $error("overflow alongside read data");

    // a read straight after a write returns value plus two
    a_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tuser == OP_WRITE) ##1 (s_acc && s_tuser == OP_READ) |=>
        m_tdata[COUNT_W-1:0] == count_t'($past(s_tdata[COUNT_W:1], 2) + WRITE_OFFSET))
        else $error("read after write mismatch");

endmodule

bind timer_counter_with_prescaler_unit tcp_checker u_tcp_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for timer_counter_with_prescaler_unit. It runs directed and random timer
// events and checks each result against a model of the count, tick phase and edge countdown.
// Depends on tcp_pkg and timer_counter_with_prescaler_unit.
module tb_top;
    import tcp_pkg::*;

    localparam int TICKS        = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 530;
    localparam int PHASES       = 11;

    typedef struct packed
    {
        logic   overflow;
        count_t read_data;
    } timer_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [0] pin_rising, [8:1] write_value, rest zero
    logic [OP_W-1:0]       s_tuser;   // [1:0] operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [7:0] read_data, [8] overflow, rest zero
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // timer model: configuration and state
    logic               mdl_ext;
    logic               mdl_falling;
    logic               mdl_bypass;
    logic [2:0]         mdl_sel;
    count_t             mdl_count;
    logic [PHASE_W-1:0] mdl_phase;
    left_t              mdl_left;

    timer_result_t result_q[$];

    int  err_cnt;
    int  results_seen;
    int  overflows_seen;
    int  cfg_writes;
    int  idle_cycles;
    int  op_seen[4];
    int  burst_left;
    bit  no_gaps;
    int  rdy_mode;
    int  rdy_cyc;

    timer_counter_with_prescaler_unit #(
        .TICKS_PER_INCREMENT(TICKS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int prescale_div();
        return mdl_bypass ? 1 : (2 << mdl_sel);
    endfunction

    function automatic timer_result_t predict_event(op_t op, logic rising, count_t wval);
        timer_result_t r;
        int limit;
        r = '0;
        limit = prescale_div() * TICKS;
        case (op)
            OP_TICK:
            begin
                if (!mdl_ext)
                begin
                    mdl_phase = mdl_phase + 1'b1;
                    // phase also wraps at its own width
                    if (mdl_phase == '0 || mdl_phase >= limit)
                    begin
                        mdl_phase  = '0;
                        mdl_count  = mdl_count + 1'b1;
                        r.overflow = (mdl_count == '0);
                    end
                end
            end
            OP_EDGE:
            begin
                if (mdl_ext && rising == !mdl_falling)
                begin
                    if (mdl_left <= 1)
                    begin
                        mdl_left   = left_t'(prescale_div());
                        mdl_count  = mdl_count + 1'b1;
                        r.overflow = (mdl_count == '0);
                    end
                    else
                    begin
                        mdl_left = mdl_left - 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                r.read_data = mdl_count;
            end
            default:
            begin
                mdl_count = wval + WRITE_OFFSET;
                if (mdl_ext)
                    mdl_left = left_t'(prescale_div());
                else
                    mdl_phase = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_EXT_CLOCK: mdl_ext     = val[0];
            REG_FALLING:   mdl_falling = val[0];
            REG_BYPASS:    mdl_bypass  = val[0];
            REG_PRESCALE:  mdl_sel     = val;
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t ERROR %s", $realtime, msg);
    endfunction

    function automatic void check_result(logic [OUT_DATA_W-1:0] word);
        timer_result_t got;
        timer_result_t exp_r;
        got = timer_result_t'(word[8:0]);
        if (result_q.size() == 0)
        begin
            note_mismatch($sformatf("result with nothing expected: read_data %0d overflow %0b",
                                    got.read_data, got.overflow));
            return;
        end
        exp_r = result_q.pop_front();
        if (got.read_data !== exp_r.read_data)
            note_mismatch($sformatf("read_data expected %0d got %0d",
                                    exp_r.read_data, got.read_data));
        if (got.overflow !== exp_r.overflow)
            note_mismatch($sformatf("overflow expected %0b got %0b",
                                    exp_r.overflow, got.overflow));
    endfunction

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_config(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                result_q.push_back(predict_event(s_tuser, s_tdata[0], s_tdata[8:1]));
                op_seen[s_tuser]++;
            end
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                results_seen++;
                if (m_tdata[8])
                    overflows_seen++;
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("timer_counter_with_prescaler_unit test failed");
                $finish;
            end
        end
    end

    // receiver stall pattern, re-chosen at random from four modes
    always @(negedge clk)
    begin
        rdy_cyc++;
        if (rdy_cyc % 64 == 0)
            rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rdy_cyc % 4 == 0);
            default: m_tready <= (rdy_cyc % 16 < 4);
        endcase
    end

    task automatic send_event(op_t op, logic rising, count_t wval);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!no_gaps)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, wval, rising};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // writes all four registers; spare data bits of one-bit registers are random
    task automatic configure(logic ext, logic falling, logic bypass, logic [2:0] sel);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        idx[0] = REG_EXT_CLOCK;
        idx[1] = REG_FALLING;
        idx[2] = REG_BYPASS;
        idx[3] = REG_PRESCALE;
        val[0] = {2'($urandom_range(0, 3)), ext};
        val[1] = {2'($urandom_range(0, 3)), falling};
        val[2] = {2'($urandom_range(0, 3)), bypass};
        val[3] = sel;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // reset configuration: external, falling edges, divisor one
    task automatic test_reset_state();
        send_event(OP_READ, 1'b0, 8'h00);
        send_event(OP_EDGE, 1'b0, 8'h00);
        send_event(OP_EDGE, 1'b1, 8'hFF);
        send_event(OP_TICK, 1'b0, 8'h00);
        send_event(OP_WRITE, 1'b0, 8'd253);
        send_event(OP_EDGE, 1'b0, 8'h00);
        send_event(OP_WRITE, 1'b1, 8'd255);
        send_event(OP_READ, 1'b1, 8'h00);
    endtask

    // wrap, phase clear on write, threshold lowered below the running phase
    task automatic test_internal_ticks();
        wait_drained();
        configure(1'b0, 1'b1, 1'b1, 3'd0);
        send_event(OP_WRITE, 1'b0, 8'd253);
        repeat (5) send_event(OP_TICK, 1'b0, 8'h00);
        send_event(OP_WRITE, 1'b0, 8'd0);
        repeat (3) send_event(OP_TICK, 1'b1, 8'h00);
        send_event(OP_READ, 1'b0, 8'h00);
        wait_drained();
        configure(1'b0, 1'b1, 1'b0, 3'd0);
        repeat (2) send_event(OP_TICK, 1'b0, 8'h00);
        wait_drained();
        configure(1'b0, 1'b1, 1'b1, 3'd0);
        send_event(OP_TICK, 1'b0, 8'h00);
        send_event(OP_READ, 1'b0, 8'h00);
    endtask

    // rising edges, countdown kept across a divisor change
    task automatic test_external_edges();
        wait_drained();
        configure(1'b1, 1'b0, 1'b0, 3'd1);
        send_event(OP_WRITE, 1'b0, 8'd0);
        repeat (2) send_event(OP_EDGE, 1'b1, 8'h00);
        send_event(OP_EDGE, 1'b0, 8'h00);
        wait_drained();
        configure(1'b1, 1'b0, 1'b0, 3'd0);
        repeat (2) send_event(OP_EDGE, 1'b1, 8'h00);
        send_event(OP_READ, 1'b0, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic   ext;
        logic   falling;
        logic   bypass;
        logic [2:0] sel;
        int     pick;
        op_t    op;
        logic   rising;
        count_t wval;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            ext     = 1'($urandom_range(0, 1));
            falling = 1'($urandom_range(0, 1));
            bypass  = 1'($urandom_range(0, 1));
            sel     = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(0, 2));
            case (ph)
                0: begin ext = 1'b0; bypass = 1'b0; sel = 3'd7; end
                1: begin ext = 1'b1; bypass = 1'b0; sel = 3'd7; end
                2: begin ext = 1'b0; bypass = 1'b1; end
                3: begin ext = 1'b1; falling = 1'b0; bypass = 1'b1; end
                4: begin ext = 1'b1; falling = 1'b1; bypass = 1'b0; sel = 3'd0; end
                default: ;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            wait_drained();
            configure(ext, falling, bypass, sel);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                pick   = $urandom_range(0, 99);
                rising = 1'($urandom_range(0, 1));
                wval   = 8'($urandom_range(0, 255));
                if (pick < 55)
                begin
                    op = ext ? OP_EDGE : OP_TICK;
                    if (ext && $urandom_range(0, 4) != 0)
                        rising = !falling;
                end
                else if (pick < 62)
                    op = ext ? OP_TICK : OP_EDGE;
                else if (pick < 80)
                    op = OP_READ;
                else
                begin
                    op = OP_WRITE;
                    if ($urandom_range(0, 1))
                        wval = 8'($urandom_range(240, 255));
                end
                send_event(op, rising, wval);
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_EXT_CLOCK;
        cfg_data    = '0;
        mdl_ext     = 1'b1;
        mdl_falling = 1'b1;
        mdl_bypass  = 1'b1;
        mdl_sel     = 3'd7;
        mdl_count   = '0;
        mdl_phase   = '0;
        mdl_left    = left_t'(1);
        err_cnt     = 0;
        results_seen   = 0;
        overflows_seen = 0;
        cfg_writes  = 0;
        idle_cycles = 0;
        op_seen     = '{0, 0, 0, 0};
        burst_left  = 0;
        no_gaps     = 1'b0;
        rdy_mode    = 0;
        rdy_cyc     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_internal_ticks();
        test_external_edges();
        test_random_traffic();

        wait_drained();
        repeat (4) @(negedge clk);
        $display("covered %0d ticks, %0d edges, %0d reads, %0d writes; %0d results checked",
                 op_seen[OP_TICK], op_seen[OP_EDGE], op_seen[OP_READ], op_seen[OP_WRITE],
                 results_seen);
        $display("%0d overflows, %0d register writes, %0d mismatches",
                 overflows_seen, cfg_writes, err_cnt);
        if (err_cnt == 0 && result_q.size() == 0)
            $display("timer_counter_with_prescaler_unit test passed");
        else
            $display("timer_counter_with_prescaler_unit test failed");
        $finish;
    end

endmodule
